### rtl/core/keyframe_curve_evaluator_unit_defines.svh
// Assertion helpers shared by the keyframe curve evaluator RTL.
`ifndef KEYFRAME_CURVE_EVALUATOR_UNIT_DEFINES_SVH
`define KEYFRAME_CURVE_EVALUATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KCE_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define KCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/kce_pkg.sv
package kce_pkg;

   // Field widths.
   localparam int VALUE_W    = 32;
   localparam int TIME_W     = 16;
   localparam int FRAC_W     = 16;
   localparam int TABLE_W    = 2;
   localparam int KEY_IDX_W  = 3;
   localparam int MODE_W     = 2;
   localparam int COUNT_W    = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int ENTRY_W    = TIME_W + VALUE_W;

   // Interpolation arithmetic.
   localparam int ALPHA_W    = FRAC_W + 1;
   localparam int DIFF_W     = VALUE_W + 1;
   localparam int PROD_W     = 50;
   localparam int DIV_CNT_W  = 4;
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'd15;

   // Evaluation modes.
   localparam logic [MODE_W-1:0] MODE_CONSTANT      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RANDOM        = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CURVE         = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RANDOM_CURVES = 2'd3;

   // Key tables.
   localparam logic [TABLE_W-1:0] TBL_MAIN = 2'd0;
   localparam logic [TABLE_W-1:0] TBL_LOW  = 2'd1;
   localparam logic [TABLE_W-1:0] TBL_HIGH = 2'd2;
   localparam logic [TABLE_W-1:0] TBL_NONE = 2'd3;

   // Request opcodes.
   localparam logic OP_EVAL  = 1'b0;
   localparam logic OP_WRITE = 1'b1;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_MODE       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CONSTANT   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAIN_COUNT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_COUNT  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_COUNT = 3'd6;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOOK_INIT,
      ST_SCAN,
      ST_RESOLVE,
      ST_DIV,
      ST_BLEND_SUB,
      ST_BLEND_MUL,
      ST_BLEND_ADD,
      ST_OUT
   } kce_state_type;

endpackage

### rtl/core/keyframe_curve_evaluator_unit.sv
// Keyframe curve evaluator.
// Requests arrive on the req_ channel (valid/stall). A write request (op = 1)
// stores one (time, value) key in the main, low or high table in the cycle it
// is accepted and gives no response. An evaluate request (op = 0) returns one
// Q16.16 value on the rsp_ channel, chosen by the mode register: constant,
// min + r*(max - min), piecewise-linear lookup in the main table, or a blend
// by r between lookups in the low and high tables.
// The unit works on one request at a time and holds req_stall high until it
// has moved its result into the output register. A lookup scans the key
// memory, one read a cycle; a lookup that lands inside a segment then runs
// the serial divider and the multiply path, and a blend of two curves does
// a lookup in each table before its own multiply path.
// While rsp_stall is high the result stays in the output register; the next
// request is still accepted and is held in its last state until the output
// register frees up. Reset clears the control and configuration registers
// and the state machine; the key memory is not cleared and keys must be
// written before they are used. The user writes registers through the csr_
// port only while the unit is idle; the unit does not enforce this.
`include "keyframe_curve_evaluator_unit_defines.svh"

module keyframe_curve_evaluator_unit #(
   parameter int MAX_KEYS = 8
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic                                   req_op,
   input  logic        [kce_pkg::TIME_W-1:0]      req_curve_t,
   input  logic        [kce_pkg::FRAC_W-1:0]      req_random_fraction,
   input  logic        [kce_pkg::TABLE_W-1:0]     req_key_table,
   input  logic        [kce_pkg::KEY_IDX_W-1:0]   req_key_index,
   input  logic        [kce_pkg::TIME_W-1:0]      req_key_time,
   input  logic signed [kce_pkg::VALUE_W-1:0]     req_key_value,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [kce_pkg::VALUE_W-1:0]     rsp_curve_value,
   input  logic                                   csr_write,
   input  logic        [kce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [kce_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import kce_pkg::*;

   localparam int IDX_W     = $clog2(MAX_KEYS);
   localparam int NUM_W     = IDX_W + 1;
   localparam int ADDR_W    = IDX_W + 2;
   localparam int MEM_DEPTH = 3 * (1 << IDX_W);

   // Control state.
   kce_state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rd_valid_ff, rd_valid_in;
   logic found_ff, found_in;

   // Configuration registers.
   logic        [MODE_W-1:0]  mode_ff, mode_in;
   logic signed [VALUE_W-1:0] const_ff, const_in;
   logic signed [VALUE_W-1:0] min_ff, min_in;
   logic signed [VALUE_W-1:0] max_ff, max_in;
   logic        [COUNT_W-1:0] main_cnt_ff, main_cnt_in;
   logic        [COUNT_W-1:0] low_cnt_ff, low_cnt_in;
   logic        [COUNT_W-1:0] high_cnt_ff, high_cnt_in;

   // Working registers.
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic        [TIME_W-1:0]  t_ff, t_in;
   logic        [FRAC_W-1:0]  r_ff, r_in;
   logic        [TABLE_W-1:0] table_ff, table_in;
   logic                      phase_ff, phase_in;
   logic        [NUM_W-1:0]   n_ff, n_in;
   logic        [NUM_W-1:0]   issue_cnt_ff, issue_cnt_in;
   logic        [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic        [TIME_W-1:0]  first_t_ff, first_t_in;
   logic signed [VALUE_W-1:0] first_v_ff, first_v_in;
   logic        [TIME_W-1:0]  prev_t_ff, prev_t_in;
   logic signed [VALUE_W-1:0] prev_v_ff, prev_v_in;
   logic        [TIME_W-1:0]  seg_ta_ff, seg_ta_in;
   logic        [TIME_W-1:0]  seg_tb_ff, seg_tb_in;
   logic signed [VALUE_W-1:0] seg_va_ff, seg_va_in;
   logic signed [VALUE_W-1:0] seg_vb_ff, seg_vb_in;
   logic        [TIME_W-1:0]  span_ff, span_in;
   logic        [ALPHA_W-1:0] rem_ff, rem_in;
   logic        [ALPHA_W-1:0] quot_ff, quot_in;
   logic        [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic signed [VALUE_W-1:0] blend_a_ff, blend_a_in;
   logic signed [VALUE_W-1:0] blend_b_ff, blend_b_in;
   logic        [ALPHA_W-1:0] blend_f_ff, blend_f_in;
   logic                      interp_ff, interp_in;
   logic signed [DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [VALUE_W-1:0] res_ff, res_in;
   logic signed [VALUE_W-1:0] lo_ff, lo_in;

   // Key memory.
   logic [ENTRY_W-1:0] key_mem [MEM_DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;
   logic               mem_wr_en, mem_rd_en;
   logic [ADDR_W-1:0]  mem_wr_addr, mem_rd_addr;
   logic [ENTRY_W-1:0] mem_wr_data;

   // Helper signals.
   logic               req_accept;
   logic [7:0]         key_idx_ext;
   logic [COUNT_W-1:0] sel_cnt;
   logic [7:0]         sel_cnt_ext;
   logic [7:0]         n_sat;
   logic [NUM_W-1:0]   n_last;
   logic [TIME_W-1:0]  e_t;
   logic signed [VALUE_W-1:0] e_v;
   logic [TIME_W-1:0]  seg_span;
   logic [TIME_W-1:0]  seg_dist;
   logic               div_top;
   logic [ALPHA_W-1:0] rem_shift;
   logic               div_bit;
   logic signed [PROD_W:0] mult_full;
   logic               look_done;
   logic signed [VALUE_W-1:0] look_val;

   assign req_stall       = (state_ff != ST_IDLE);
   assign req_accept      = req_valid && !req_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_curve_value = rsp_value_ff;

   assign key_idx_ext = {5'd0, req_key_index};
   assign n_last      = n_ff - NUM_W'(1);
   assign e_t         = rd_data_ff[ENTRY_W-1:VALUE_W];
   assign e_v         = $signed(rd_data_ff[VALUE_W-1:0]);
   assign seg_span    = seg_tb_ff - seg_ta_ff;
   assign seg_dist    = t_ff - seg_ta_ff;
   assign div_top     = (seg_dist >= seg_span);
   assign rem_shift   = {rem_ff[ALPHA_W-2:0], 1'b0};
   assign div_bit     = (rem_shift >= {1'b0, span_ff});
   assign mult_full   = diff_ff * $signed({1'b0, blend_f_ff});

   // Key count of the table being looked up, saturated to the table size.
   always_comb begin
      case (table_ff)
         TBL_MAIN: sel_cnt = main_cnt_ff;
         TBL_LOW:  sel_cnt = low_cnt_ff;
         default:  sel_cnt = high_cnt_ff;
      endcase
      sel_cnt_ext = {4'd0, sel_cnt};
      n_sat = (sel_cnt_ext > 8'(MAX_KEYS)) ? 8'(MAX_KEYS) : sel_cnt_ext;
   end

   // Next state, datapath and memory control.
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rd_valid_in  = 1'b0;
      found_in     = found_ff;
      mode_in      = mode_ff;
      const_in     = const_ff;
      min_in       = min_ff;
      max_in       = max_ff;
      main_cnt_in  = main_cnt_ff;
      low_cnt_in   = low_cnt_ff;
      high_cnt_in  = high_cnt_ff;
      t_in         = t_ff;
      r_in         = r_ff;
      table_in     = table_ff;
      phase_in     = phase_ff;
      n_in         = n_ff;
      issue_cnt_in = issue_cnt_ff;
      rd_idx_in    = rd_idx_ff;
      first_t_in   = first_t_ff;
      first_v_in   = first_v_ff;
      prev_t_in    = prev_t_ff;
      prev_v_in    = prev_v_ff;
      seg_ta_in    = seg_ta_ff;
      seg_tb_in    = seg_tb_ff;
      seg_va_in    = seg_va_ff;
      seg_vb_in    = seg_vb_ff;
      span_in      = span_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      div_cnt_in   = div_cnt_ff;
      blend_a_in   = blend_a_ff;
      blend_b_in   = blend_b_ff;
      blend_f_in   = blend_f_ff;
      interp_in    = interp_ff;
      diff_in      = diff_ff;
      prod_in      = prod_ff;
      res_in       = res_ff;
      lo_in        = lo_ff;
      mem_wr_en    = 1'b0;
      mem_wr_addr  = {req_key_table, key_idx_ext[IDX_W-1:0]};
      mem_wr_data  = {req_key_time, req_key_value};
      mem_rd_en    = 1'b0;
      mem_rd_addr  = {table_ff, issue_cnt_ff[IDX_W-1:0]};
      look_done    = 1'b0;
      look_val     = '0;

      // Register writes.
      if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:       mode_in     = csr_wdata[MODE_W-1:0];
            CSR_CONSTANT:   const_in    = $signed(csr_wdata[VALUE_W-1:0]);
            CSR_MIN:        min_in      = $signed(csr_wdata[VALUE_W-1:0]);
            CSR_MAX:        max_in      = $signed(csr_wdata[VALUE_W-1:0]);
            CSR_MAIN_COUNT: main_cnt_in = csr_wdata[COUNT_W-1:0];
            CSR_LOW_COUNT:  low_cnt_in  = csr_wdata[COUNT_W-1:0];
            CSR_HIGH_COUNT: high_cnt_in = csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // Take a request: key writes finish here, evaluations start.
         ST_IDLE: begin
            if (req_accept) begin
               t_in = req_curve_t;
               r_in = req_random_fraction;
               if (req_op == OP_WRITE) begin
                  mem_wr_en = (req_key_table != TBL_NONE) &&
                              (key_idx_ext < 8'(MAX_KEYS));
               end else begin
                  unique case (mode_ff)
                     MODE_CONSTANT: begin
                        res_in   = const_ff;
                        state_in = ST_OUT;
                     end
                     MODE_RANDOM: begin
                        blend_a_in = min_ff;
                        blend_b_in = max_ff;
                        blend_f_in = {1'b0, req_random_fraction};
                        interp_in  = 1'b0;
                        state_in   = ST_BLEND_SUB;
                     end
                     MODE_CURVE: begin
                        table_in = TBL_MAIN;
                        state_in = ST_LOOK_INIT;
                     end
                     MODE_RANDOM_CURVES: begin
                        table_in = TBL_LOW;
                        phase_in = 1'b0;
                        state_in = ST_LOOK_INIT;
                     end
                  endcase
               end
            end
         end

         // Start a table lookup; an empty table gives zero at once.
         ST_LOOK_INIT: begin
            n_in         = n_sat[NUM_W-1:0];
            issue_cnt_in = '0;
            found_in     = 1'b0;
            if (n_sat == 8'd0) begin
               look_done = 1'b1;
               look_val  = '0;
            end else begin
               state_in = ST_SCAN;
            end
         end

         // Read keys one per cycle and track first, last and the bracketing segment.
         ST_SCAN: begin
            if (issue_cnt_ff != n_ff) begin
               mem_rd_en    = 1'b1;
               rd_valid_in  = 1'b1;
               rd_idx_in    = issue_cnt_ff[IDX_W-1:0];
               issue_cnt_in = issue_cnt_ff + NUM_W'(1);
            end
            if (rd_valid_ff) begin
               if (rd_idx_ff == '0) begin
                  first_t_in = e_t;
                  first_v_in = e_v;
               end else if (!found_ff && (prev_t_ff <= t_ff) && (t_ff <= e_t)) begin
                  found_in  = 1'b1;
                  seg_ta_in = prev_t_ff;
                  seg_tb_in = e_t;
                  seg_va_in = prev_v_ff;
                  seg_vb_in = e_v;
               end
               prev_t_in = e_t;
               prev_v_in = e_v;
               if ({1'b0, rd_idx_ff} == n_last) begin
                  state_in = ST_RESOLVE;
               end
            end
         end

         // Clamp to the end keys or set up the segment interpolation.
         ST_RESOLVE: begin
            if (t_ff <= first_t_ff) begin
               look_done = 1'b1;
               look_val  = first_v_ff;
            end else if (t_ff >= prev_t_ff) begin
               look_done = 1'b1;
               look_val  = prev_v_ff;
            end else if (found_ff) begin
               if (seg_span == '0) begin
                  look_done = 1'b1;
                  look_val  = seg_va_ff;
               end else begin
                  span_in    = seg_span;
                  rem_in     = {1'b0, seg_dist} - (div_top ? {1'b0, seg_span} : '0);
                  quot_in    = {{(ALPHA_W-1){1'b0}}, div_top};
                  div_cnt_in = '0;
                  blend_a_in = seg_va_ff;
                  blend_b_in = seg_vb_ff;
                  interp_in  = 1'b1;
                  state_in   = ST_DIV;
               end
            end else begin
               look_done = 1'b1;
               look_val  = prev_v_ff;
            end
         end

         // Restoring division, one quotient bit per cycle.
         ST_DIV: begin
            rem_in     = div_bit ? (rem_shift - {1'b0, span_ff}) : rem_shift;
            quot_in    = {quot_ff[ALPHA_W-2:0], div_bit};
            div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_LAST) begin
               blend_f_in = {quot_ff[ALPHA_W-2:0], div_bit};
               state_in   = ST_BLEND_SUB;
            end
         end

         // Blend a + floor((b - a) * f / 65536) over three registered steps.
         ST_BLEND_SUB: begin
            diff_in  = DIFF_W'(blend_b_ff) - DIFF_W'(blend_a_ff);
            state_in = ST_BLEND_MUL;
         end

         ST_BLEND_MUL: begin
            prod_in  = mult_full[PROD_W-1:0];
            state_in = ST_BLEND_ADD;
         end

         ST_BLEND_ADD: begin
            if (interp_ff) begin
               look_done = 1'b1;
               look_val  = blend_a_ff + $signed(prod_ff[VALUE_W+FRAC_W-1:FRAC_W]);
            end else begin
               res_in   = blend_a_ff + $signed(prod_ff[VALUE_W+FRAC_W-1:FRAC_W]);
               state_in = ST_OUT;
            end
         end

         // Move the result into the output register once it is free.
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // A finished lookup either is the result or feeds the curve blend.
      if (look_done) begin
         case (mode_ff)
            MODE_RANDOM_CURVES: begin
               if (!phase_ff) begin
                  lo_in    = look_val;
                  phase_in = 1'b1;
                  table_in = TBL_HIGH;
                  state_in = ST_LOOK_INIT;
               end else begin
                  blend_a_in = lo_ff;
                  blend_b_in = look_val;
                  blend_f_in = {1'b0, r_ff};
                  interp_in  = 1'b0;
                  state_in   = ST_BLEND_SUB;
               end
            end
            default: begin
               res_in   = look_val;
               state_in = ST_OUT;
            end
         endcase
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         mode_ff      <= MODE_CONSTANT;
         const_ff     <= '0;
         min_ff       <= '0;
         max_ff       <= '0;
         main_cnt_ff  <= '0;
         low_cnt_ff   <= '0;
         high_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         mode_ff      <= mode_in;
         const_ff     <= const_in;
         min_ff       <= min_in;
         max_ff       <= max_in;
         main_cnt_ff  <= main_cnt_in;
         low_cnt_ff   <= low_cnt_in;
         high_cnt_ff  <= high_cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      t_ff         <= t_in;
      r_ff         <= r_in;
      table_ff     <= table_in;
      phase_ff     <= phase_in;
      n_ff         <= n_in;
      issue_cnt_ff <= issue_cnt_in;
      rd_idx_ff    <= rd_idx_in;
      first_t_ff   <= first_t_in;
      first_v_ff   <= first_v_in;
      prev_t_ff    <= prev_t_in;
      prev_v_ff    <= prev_v_in;
      seg_ta_ff    <= seg_ta_in;
      seg_tb_ff    <= seg_tb_in;
      seg_va_ff    <= seg_va_in;
      seg_vb_ff    <= seg_vb_in;
      span_ff      <= span_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      div_cnt_ff   <= div_cnt_in;
      blend_a_ff   <= blend_a_in;
      blend_b_ff   <= blend_b_in;
      blend_f_ff   <= blend_f_in;
      interp_ff    <= interp_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      res_ff       <= res_in;
      lo_ff        <= lo_in;
   end

   // Key memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         key_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= key_mem[mem_rd_addr];
      end
   end

   // Read data only returns while a table scan is running.
   `KCE_ASSERT_HOLDS(a_read_in_scan, clock, reset, rd_valid_ff, state_ff == ST_SCAN, "read data outside scan")

   // The scan never issues past the saturated key count.
   `KCE_ASSERT_HOLDS(a_issue_bound, clock, reset, state_ff == ST_SCAN, issue_cnt_ff <= n_ff, "scan issued past key count")

   // The divider remainder always stays below the segment span.
   `KCE_ASSERT_HOLDS(a_div_rem, clock, reset, state_ff == ST_DIV, rem_ff < {1'b0, span_ff}, "divider remainder out of range")

   // A new response only appears after the output state.
   `KCE_ASSERT_NEXT(a_rsp_source, clock, reset, !rsp_valid_ff && state_ff != ST_OUT, !rsp_valid_ff, "response without output state")

endmodule
